// ===== rtl/ttlc_pkg.sv =====
// ttlc_pkg: shared types, codes and defaults for the ttl result cache
// used by ttlc_ctrl, ttlc_dp and ttl_result_cache; no dependencies
package ttlc_pkg;

  // default sizes
  localparam int CapacityDef    = 16;
  localparam int KeyBitsDef     = 64;
  localparam int PayloadBitsDef = 64;

  // fixed field widths
  localparam int TtlW    = 32;
  localparam int CfgIdxW = 8;

  // ttl defaults, also loaded when zero is written
  localparam logic [TtlW-1:0] POS_TTL_RST = 32'd3600;
  localparam logic [TtlW-1:0] NEG_TTL_RST = 32'd300;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_POS_TTL = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_NEG_TTL = 8'd1;

  typedef enum logic [1:0] {
    OP_LOOKUP    = 2'd0,
    OP_STORE_POS = 2'd1,
    OP_STORE_NEG = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_POS_HIT = 2'd0,
    STATUS_MISS    = 2'd1,
    STATUS_NEG_HIT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_EXEC = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] lookup_key;
    logic [31:0] now_time;
    logic [63:0] store_payload;
    logic [3:0]  store_code;
  } req_t;

  typedef struct packed {
    logic [1:0]  lookup_status;
    logic [3:0]  hit_code;
    logic [63:0] hit_payload;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic req_load;
    logic cmp_en;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_lookup;
  } sts_t;

endpackage

// ===== rtl/ttlc_ctrl.sv =====
// ttlc_ctrl: sequencing fsm and output valid flag for the ttl result cache
// depends on ttlc_pkg
module ttlc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ttlc_pkg::sts_t    sts_i,
  output ttlc_pkg::cmd_t    cmd_o
);

  ttlc_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic exec_done;
  logic accept;

  // a lookup may only finish once the output register is free
  assign exec_done = !sts_i.is_lookup || !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ttlc_pkg::ST_IDLE: begin
        if (accept) state_d = ttlc_pkg::ST_CMP;
      end
      ttlc_pkg::ST_CMP: begin
        state_d = ttlc_pkg::ST_EXEC;
      end
      ttlc_pkg::ST_EXEC: begin
        if (exec_done) state_d = accept ? ttlc_pkg::ST_CMP : ttlc_pkg::ST_IDLE;
      end
      default: begin
        state_d = ttlc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.cmp_en   = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      ttlc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ttlc_pkg::ST_CMP: begin
        cmd_o.cmp_en = 1'b1;
      end
      ttlc_pkg::ST_EXEC: begin
        cmd_o.commit = exec_done;
        in_ready_o   = exec_done;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    cmd_o.req_load = in_valid_i && in_ready_o;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit && sts_i.is_lookup) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttlc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ttlc_pkg::ST_CMP)
    else $error("accepted transaction did not start compare");

  a_cmp_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ttlc_pkg::ST_CMP |=> state_q == ttlc_pkg::ST_EXEC)
    else $error("compare not followed by execute");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit && sts_i.is_lookup) |-> (!out_valid_q || out_ready_i))
    else $error("lookup result would overwrite a pending result");

endmodule

// ===== rtl/ttlc_dp.sv =====
// ttlc_dp: entry storage, key compare, age check, victim pointer, ttl registers
// and result register of the ttl result cache; depends on ttlc_pkg
module ttlc_dp #(
  parameter int CAPACITY     = ttlc_pkg::CapacityDef,
  parameter int KEY_BITS     = ttlc_pkg::KeyBitsDef,
  parameter int PAYLOAD_BITS = ttlc_pkg::PayloadBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttlc_pkg::req_t                req_i,
  output ttlc_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [ttlc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttlc_pkg::TtlW-1:0]     cfg_wdata_i,
  input  ttlc_pkg::cmd_t                cmd_i,
  output ttlc_pkg::sts_t                sts_o
);

  localparam int IdxW = $clog2(CAPACITY);

  ttlc_pkg::req_t req_q;
  ttlc_pkg::rsp_t rsp_q;

  logic [ttlc_pkg::TtlW-1:0] pos_ttl_q, neg_ttl_q;

  logic [CAPACITY-1:0]     valid_q;
  logic [KEY_BITS-1:0]     key_q     [CAPACITY];
  logic [31:0]             time_q    [CAPACITY];
  logic [3:0]              code_q    [CAPACITY];
  logic [PAYLOAD_BITS-1:0] payload_q [CAPACITY];
  logic [CAPACITY-1:0]     match_q;
  logic [IdxW-1:0]         victim_q;

  logic [KEY_BITS-1:0] req_key;
  logic                hit;
  logic [IdxW-1:0]     hit_idx;
  logic [IdxW-1:0]     wr_idx;
  logic [32:0]         diff;
  logic [31:0]         age;
  logic [31:0]         ttl;
  logic                expired;
  logic                is_store;
  logic                rd_neg;
  ttlc_pkg::rsp_t      rsp_d;

  assign req_key = req_q.lookup_key[KEY_BITS-1:0];

  // ttl registers, zero writes fall back to the default
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_ttl_q <= ttlc_pkg::POS_TTL_RST;
      neg_ttl_q <= ttlc_pkg::NEG_TTL_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ttlc_pkg::CFG_POS_TTL) begin
        pos_ttl_q <= (cfg_wdata_i != '0) ? cfg_wdata_i : ttlc_pkg::POS_TTL_RST;
      end
      if (cfg_idx_i == ttlc_pkg::CFG_NEG_TTL) begin
        neg_ttl_q <= (cfg_wdata_i != '0) ? cfg_wdata_i : ttlc_pkg::NEG_TTL_RST;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) req_q <= req_i;
  end

  // key compare across all entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
    end else if (cmd_i.cmp_en) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match_q[i] <= valid_q[i] && (key_q[i] == req_key);
      end
    end
  end

  // at most one bit is set, so or-ing the indexes encodes it
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_q[i]) hit_idx = hit_idx | IdxW'(i);
    end
  end

  assign hit     = |match_q;
  assign rd_neg  = code_q[hit_idx] != 4'd0;
  assign diff    = {1'b0, req_q.now_time} - {1'b0, time_q[hit_idx]};
  assign age     = diff[32] ? 32'd0 : diff[31:0];
  assign ttl     = rd_neg ? neg_ttl_q : pos_ttl_q;
  assign expired = age > ttl;

  assign is_store = (req_q.operation == ttlc_pkg::OP_STORE_POS)
                 || ((req_q.operation == ttlc_pkg::OP_STORE_NEG) && (req_q.store_code != 4'd0));
  assign wr_idx   = hit ? hit_idx : victim_q;

  assign sts_o.is_lookup = req_q.operation == ttlc_pkg::OP_LOOKUP;

  always_comb begin
    rsp_d.lookup_status = ttlc_pkg::STATUS_MISS;
    rsp_d.hit_code      = 4'd0;
    rsp_d.hit_payload   = 64'd0;
    if (hit && !expired) begin
      if (rd_neg) begin
        rsp_d.lookup_status = ttlc_pkg::STATUS_NEG_HIT;
        rsp_d.hit_code      = code_q[hit_idx];
      end else begin
        rsp_d.lookup_status = ttlc_pkg::STATUS_POS_HIT;
        rsp_d.hit_payload   = 64'(payload_q[hit_idx]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && sts_o.is_lookup) rsp_q <= rsp_d;
  end

  // valid bits and victim pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      victim_q <= '0;
    end else if (cmd_i.commit) begin
      if (sts_o.is_lookup && hit && expired) begin
        valid_q[hit_idx] <= 1'b0;
      end
      if (is_store) begin
        valid_q[wr_idx] <= 1'b1;
        if (!hit) begin
          victim_q <= (victim_q == IdxW'(CAPACITY - 1)) ? '0 : victim_q + 1'b1;
        end
      end
    end
  end

  // entry contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && is_store) begin
      key_q[wr_idx]  <= req_key;
      time_q[wr_idx] <= req_q.now_time;
      if (req_q.operation == ttlc_pkg::OP_STORE_POS) begin
        code_q[wr_idx]    <= 4'd0;
        payload_q[wr_idx] <= req_q.store_payload[PAYLOAD_BITS-1:0];
      end else begin
        code_q[wr_idx]    <= req_q.store_code;
        payload_q[wr_idx] <= '0;
      end
    end
  end

  assign rsp_o = rsp_q;

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_q))
    else $error("key held by more than one entry");

  a_victim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    victim_q <= IdxW'(CAPACITY - 1))
    else $error("victim pointer out of range");

  a_ttl_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_ttl_q != '0) && (neg_ttl_q != '0))
    else $error("ttl register holds zero");

endmodule

// ===== rtl/ttl_result_cache.sv =====
// ttl_result_cache: top level of the fully associative ttl result cache
// instantiates ttlc_ctrl and ttlc_dp; depends on ttlc_pkg
//
// fully associative cache of CAPACITY entries holding positive answers
// (payload) and negative answers (nonzero error code) under separate
// lifetimes set by positive_ttl (index 0) and negative_ttl (index 1);
// writing zero to either loads its default (3600 / 300). each transaction
// passes through a compare cycle that matches the key against all valid
// entries, then an execute cycle that checks age = now - stored time
// (clamped at 0), updates the entry and, for a lookup, loads the result
// register. a new transaction is taken in the execute cycle of the previous
// one; a lookup stalls in execute only while the result register still
// holds an untaken result. stores produce no result; a store reuses the
// matching entry or replaces the round-robin victim. no clearing pass
// after reset
module ttl_result_cache #(
  parameter int CAPACITY     = ttlc_pkg::CapacityDef,
  parameter int KEY_BITS     = ttlc_pkg::KeyBitsDef,
  parameter int PAYLOAD_BITS = ttlc_pkg::PayloadBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request transactions
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ttlc_pkg::req_t                in_data_i,
  // result transactions, lookups only
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ttlc_pkg::rsp_t                out_data_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [ttlc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttlc_pkg::TtlW-1:0]     cfg_wdata_i
);

  ttlc_pkg::cmd_t cmd;
  ttlc_pkg::sts_t sts;

  // sequencing: idle, compare, execute
  ttlc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // entries, compare, age check and result register
  ttlc_dp #(
    .CAPACITY     (CAPACITY),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_data_i),
    .rsp_o       (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
